### rtl/core/scaled_3x3_convolution_assert.svh
// Assertion macros shared by the checker of the scaled 3x3 convolution.
// Self-contained; each macro expands to one labeled concurrent assertion.
`ifndef SCALED_3X3_CONVOLUTION_ASSERT_SVH
`define SCALED_3X3_CONVOLUTION_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scc: port check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scc: port check failed");

// Next-cycle implication that is checked through reset as well.
`define SCC_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scc: port check failed");

`endif

### rtl/core/scc_pkg.sv
// Shared constants, types and helpers of the scaled 3x3 convolution.
// No dependencies; other files but the macro header use it by scoped names.
`timescale 1ns / 1ps

package scc_pkg;

  // Field and register widths.
  localparam int PIXEL_BITS     = 8;
  localparam int TAP_BITS       = 8;
  localparam int TAPS_PER_ROW   = 3;
  localparam int LINE_MAX_DEF   = 1024;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int CCOL_BITS      = 10;
  localparam int RESULT_BITS    = 20;

  // Arithmetic widths: signed tap times zero-extended pixel, then sums.
  localparam int PROD_BITS = PIXEL_BITS + TAP_BITS + 1;
  localparam int PSUM_BITS = PROD_BITS + 2;
  localparam int ACC_BITS  = PSUM_BITS + 2;

  // Smallest usable image dimension and the scaled offset of nine terms.
  localparam int MIN_DIM       = 3;
  localparam int OFFSET_SCALED = 2250;

  // Register reset values.
  localparam logic [CFG_DATA_BITS-1:0]  KERNEL_TOP_RST = 24'h00FF00;
  localparam logic [CFG_DATA_BITS-1:0]  KERNEL_MID_RST = 24'hFF05FF;
  localparam logic [CFG_DATA_BITS-1:0]  KERNEL_BOT_RST = 24'h00FF00;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RST      = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0]    HEIGHT_RST     = 16'd1024;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_KERNEL_TOP   = 3'd0,
    CFG_KERNEL_MID   = 3'd1,
    CFG_KERNEL_BOT   = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_index_t;

  // One window column (index 0 is the oldest row) and its three taps.
  typedef logic [TAPS_PER_ROW-1:0][PIXEL_BITS-1:0] pix_col_t;
  typedef logic [TAPS_PER_ROW-1:0][TAP_BITS-1:0]   tap_col_t;

  // Tap at a position of a kernel row register, left tap in the low bits.
  function automatic logic [TAP_BITS-1:0] tap_at(input logic [CFG_DATA_BITS-1:0] row,
                                                 input int pos);
    return row[pos*TAP_BITS +: TAP_BITS];
  endfunction

endpackage

### rtl/core/scc_line_store.sv
// Two line stores holding the two previous image rows.
// Depends on scc_pkg for the pixel width.
`timescale 1ns / 1ps

module scc_line_store #(
  parameter int LINE_MAX = scc_pkg::LINE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [$clog2(LINE_MAX)-1:0]     rd_addr,
  input  logic [scc_pkg::PIXEL_BITS-1:0]  px_in,
  input  logic                            up_we,
  input  logic [$clog2(LINE_MAX)-1:0]     up_addr,
  output logic [scc_pkg::PIXEL_BITS-1:0]  top_out,
  output logic [scc_pkg::PIXEL_BITS-1:0]  mid_out
);

  logic [scc_pkg::PIXEL_BITS-1:0] upper_mem [LINE_MAX];
  logic [scc_pkg::PIXEL_BITS-1:0] lower_mem [LINE_MAX];
  logic [scc_pkg::PIXEL_BITS-1:0] top_r;
  logic [scc_pkg::PIXEL_BITS-1:0] mid_r;

  // Read both rows at the column of an accepted word; the new pixel replaces
  // the lower row entry, and the old value is returned.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r                <= upper_mem[rd_addr];
      mid_r                <= lower_mem[rd_addr];
      lower_mem[rd_addr]   <= px_in;
    end
  end

  // The displaced lower row pixel moves up into the upper row on up_we.
  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[up_addr] <= mid_r;
    end
  end

  assign top_out = top_r;
  assign mid_out = mid_r;

endmodule

### rtl/core/scc_cell.sv
// One window column cell: holds three pixels, hands them to its left
// neighbor and forms the column's partial sum. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic                                 calc_en,
  input  scc_pkg::pix_col_t                    col_in,
  input  scc_pkg::tap_col_t                    taps,
  output scc_pkg::pix_col_t                    col_out,
  output logic signed [scc_pkg::PSUM_BITS-1:0] psum_out
);

  scc_pkg::pix_col_t                   col_r;
  logic signed [scc_pkg::PROD_BITS-1:0] prod [scc_pkg::TAPS_PER_ROW];
  logic signed [scc_pkg::PSUM_BITS-1:0] psum_nxt;
  logic signed [scc_pkg::PSUM_BITS-1:0] psum_r;

  // Column register: takes the neighbor's column whenever the window shifts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  // Three signed taps times unsigned pixels, summed over the column.
  always_comb begin
    psum_nxt = '0;
    for (int i = 0; i < scc_pkg::TAPS_PER_ROW; i++) begin
      prod[i]  = $signed({1'b0, col_r[i]}) * $signed(taps[i]);
      psum_nxt = psum_nxt + scc_pkg::PSUM_BITS'(prod[i]);
    end
  end

  // Partial sum register, loaded when the window's word moves on.
  always_ff @(posedge clk) begin
    if (calc_en) begin
      psum_r <= psum_nxt;
    end
  end

  assign col_out  = col_r;
  assign psum_out = psum_r;

endmodule

### rtl/core/scaled_3x3_convolution.sv
// Scaled 3x3 convolution over a raster pixel stream; uses scc_pkg, scc_line_store, scc_cell.
// Throughput: one pixel word per cycle unless the result side stalls, set by the single
// read of each line store per word. Results go through stages A, B, C and the output register.
// Border pixels give no result; stalls on the result side back up through a bubble-free pipe.
// Reset (synchronous, rst_n low) clears counters, window, pipeline valids and configuration
// registers; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module scaled_3x3_convolution #(
  parameter int LINE_MAX = scc_pkg::LINE_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [scc_pkg::PIXEL_BITS-1:0]         in_pixel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [scc_pkg::RESULT_BITS-1:0] out_scaled_result,
  output logic [scc_pkg::HEIGHT_BITS-1:0]        out_center_row,
  output logic [scc_pkg::CCOL_BITS-1:0]          out_center_col,
  output logic                                   out_frame_end,
  input  logic                                   cfg_we,
  input  logic [scc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [scc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int WW = (CW + 1 > scc_pkg::WIDTH_REG_BITS) ? CW + 1 : scc_pkg::WIDTH_REG_BITS;
  localparam int HW = scc_pkg::HEIGHT_BITS + 1;
  localparam int NC = scc_pkg::TAPS_PER_ROW;

  // Configuration registers.
  logic [scc_pkg::CFG_DATA_BITS-1:0]  kernel_top_r, kernel_mid_r, kernel_bot_r;
  logic [scc_pkg::WIDTH_REG_BITS-1:0] image_width_r;
  logic [scc_pkg::HEIGHT_BITS-1:0]    image_height_r;

  // Raster position.
  logic [CW-1:0]                   col_cnt_r, col_cnt_nxt, col_g;
  logic [scc_pkg::HEIGHT_BITS-1:0] row_cnt_r, row_cnt_nxt, row_g, eff_h, crow;
  logic [WW-1:0]                   width_ext, eff_w, ccol_full;
  logic                            col_wrap, row_wrap, emit, fend;

  // Pipeline handshake.
  logic in_acc, out_ready, c_ready, b_ready, a_ready, a_go, b_go, c_go;

  // Stage A: accepted word and line store reads.
  logic                            va_r, va_nxt;
  logic [scc_pkg::PIXEL_BITS-1:0]  px_a_r;
  logic [CW-1:0]                   addr_a_r;
  logic                            emit_a_r, fend_a_r;
  logic [scc_pkg::HEIGHT_BITS-1:0] crow_a_r;
  logic [scc_pkg::CCOL_BITS-1:0]   ccol_a_r;
  logic [scc_pkg::PIXEL_BITS-1:0]  top_px, mid_px;

  // Stage B: window in the cell chain.
  logic                            vb_r, vb_nxt;
  logic                            emit_b_r, fend_b_r;
  logic [scc_pkg::HEIGHT_BITS-1:0] crow_b_r;
  logic [scc_pkg::CCOL_BITS-1:0]   ccol_b_r;

  // Stage C: partial sums in the cells.
  logic                            vc_r, vc_nxt;
  logic                            fend_c_r;
  logic [scc_pkg::HEIGHT_BITS-1:0] crow_c_r;
  logic [scc_pkg::CCOL_BITS-1:0]   ccol_c_r;

  // Output register.
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [scc_pkg::RESULT_BITS-1:0] result_r;
  logic signed [scc_pkg::ACC_BITS-1:0]    acc;
  logic [scc_pkg::HEIGHT_BITS-1:0]        crow_o_r;
  logic [scc_pkg::CCOL_BITS-1:0]          ccol_o_r;
  logic                                   fend_o_r;

  // Cell chain wiring.
  scc_pkg::pix_col_t                   col_in_w  [NC];
  scc_pkg::pix_col_t                   col_out_w [NC];
  scc_pkg::tap_col_t                   taps_w    [NC];
  logic signed [scc_pkg::PSUM_BITS-1:0] psum_w    [NC];

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_top_r   <= scc_pkg::KERNEL_TOP_RST;
      kernel_mid_r   <= scc_pkg::KERNEL_MID_RST;
      kernel_bot_r   <= scc_pkg::KERNEL_BOT_RST;
      image_width_r  <= scc_pkg::WIDTH_RST;
      image_height_r <= scc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::CFG_KERNEL_TOP:   kernel_top_r   <= cfg_data;
        scc_pkg::CFG_KERNEL_MID:   kernel_mid_r   <= cfg_data;
        scc_pkg::CFG_KERNEL_BOT:   kernel_bot_r   <= cfg_data;
        scc_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[scc_pkg::WIDTH_REG_BITS-1:0];
        scc_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[scc_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: width clamped to [MIN_DIM, line store depth], height at least MIN_DIM.
  always_comb begin
    width_ext = WW'(image_width_r);
    priority if (width_ext < WW'(scc_pkg::MIN_DIM)) begin
      eff_w = WW'(scc_pkg::MIN_DIM);
    end else if (width_ext > WW'(LINE_MAX)) begin
      eff_w = WW'(LINE_MAX);
    end else begin
      eff_w = width_ext;
    end
    eff_h = (image_height_r < scc_pkg::HEIGHT_BITS'(scc_pkg::MIN_DIM)) ?
            scc_pkg::HEIGHT_BITS'(scc_pkg::MIN_DIM) : image_height_r;
  end

  // Current position, restarted if a geometry change left it out of range.
  always_comb begin
    col_g     = (WW'(col_cnt_r) >= eff_w) ? '0 : col_cnt_r;
    row_g     = (row_cnt_r >= eff_h) ? '0 : row_cnt_r;
    col_wrap  = (WW'(col_g) + WW'(1)) >= eff_w;
    row_wrap  = (HW'(row_g) + HW'(1)) >= HW'(eff_h);
    emit      = (row_g >= scc_pkg::HEIGHT_BITS'(2)) && (WW'(col_g) >= WW'(2));
    fend      = (row_g == eff_h - scc_pkg::HEIGHT_BITS'(1)) &&
                (WW'(col_g) == eff_w - WW'(1));
    ccol_full = WW'(col_g) - WW'(1);
    crow      = row_g - scc_pkg::HEIGHT_BITS'(1);
    if (col_wrap) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = row_wrap ? '0 : row_g + scc_pkg::HEIGHT_BITS'(1);
    end else begin
      col_cnt_nxt = col_g + CW'(1);
      row_cnt_nxt = row_g;
    end
  end

  // Raster counters advance with every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Each stage loads when it is empty or when its word moves on.
  always_comb begin
    out_ready = !out_valid_r || !out_stall;
    c_ready   = !vc_r || out_ready;
    b_ready   = !vb_r || c_ready;
    a_ready   = !va_r || b_ready;
    in_stall  = !a_ready;
    in_acc    = in_valid && a_ready;
    a_go      = va_r && b_ready;
    b_go      = vb_r && c_ready;
    c_go      = vc_r && out_ready;
  end

  // Valid bits of the pipeline; border words end at the window stage.
  always_comb begin
    va_nxt        = in_acc ? 1'b1 : (a_go ? 1'b0 : va_r);
    vb_nxt        = a_go ? 1'b1 : (b_go ? 1'b0 : vb_r);
    vc_nxt        = b_go ? emit_b_r : (c_go ? 1'b0 : vc_r);
    out_valid_nxt = c_go || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_a_r   <= in_pixel;
      addr_a_r <= col_g;
      emit_a_r <= emit;
      fend_a_r <= fend;
      crow_a_r <= crow;
      ccol_a_r <= ccol_full[scc_pkg::CCOL_BITS-1:0];
    end
  end

  scc_line_store #(
    .LINE_MAX (LINE_MAX)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_g),
    .px_in   (in_pixel),
    .up_we   (a_go),
    .up_addr (addr_a_r),
    .top_out (top_px),
    .mid_out (mid_px)
  );

  // Stage B payload.
  always_ff @(posedge clk) begin
    if (a_go) begin
      emit_b_r <= emit_a_r;
      fend_b_r <= fend_a_r;
      crow_b_r <= crow_a_r;
      ccol_b_r <= ccol_a_r;
    end
  end

  // Cell chain: the newest column enters at the right end and moves left.
  assign col_in_w[NC-1] = {px_a_r, mid_px, top_px};

  for (genvar k = 0; k < NC; k++) begin : g_cell
    if (k < NC - 1) begin : g_link
      assign col_in_w[k] = col_out_w[k+1];
    end

    assign taps_w[k] = {scc_pkg::tap_at(kernel_bot_r, k),
                        scc_pkg::tap_at(kernel_mid_r, k),
                        scc_pkg::tap_at(kernel_top_r, k)};

    scc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (a_go),
      .calc_en  (b_go),
      .col_in   (col_in_w[k]),
      .taps     (taps_w[k]),
      .col_out  (col_out_w[k]),
      .psum_out (psum_w[k])
    );
  end

  // Stage C payload.
  always_ff @(posedge clk) begin
    if (b_go) begin
      fend_c_r <= fend_b_r;
      crow_c_r <= crow_b_r;
      ccol_c_r <= ccol_b_r;
    end
  end

  // Column partial sums plus the scaled offset.
  always_comb begin
    acc = scc_pkg::ACC_BITS'(scc_pkg::OFFSET_SCALED);
    for (int i = 0; i < NC; i++) begin
      acc = acc + scc_pkg::ACC_BITS'(psum_w[i]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (c_go) begin
      result_r <= acc[scc_pkg::RESULT_BITS-1:0];
      crow_o_r <= crow_c_r;
      ccol_o_r <= ccol_c_r;
      fend_o_r <= fend_c_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scaled_result = result_r;
  assign out_center_row    = crow_o_r;
  assign out_center_col    = ccol_o_r;
  assign out_frame_end     = fend_o_r;

endmodule

### rtl/core/scc_port_checker.sv
// Port-level checks of the scaled 3x3 convolution, bound to the top level.
// Depends on scc_pkg and the macros in scaled_3x3_convolution_assert.svh.
`timescale 1ns / 1ps
`include "scaled_3x3_convolution_assert.svh"

module scc_port_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [scc_pkg::RESULT_BITS-1:0] out_scaled_result,
  input logic [scc_pkg::HEIGHT_BITS-1:0]        out_center_row,
  input logic [scc_pkg::CCOL_BITS-1:0]          out_center_col,
  input logic                                   out_frame_end
);

  // A stalled result word stays offered.
  `SCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A stalled result word keeps its fields.
  `SCC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_scaled_result) && $stable(out_center_row) && $stable(out_center_col) && $stable(out_frame_end))

  // Results come from interior windows only, so the center row is never the first.
  `SCC_ASSERT_IMPL(a_interior_row, clk, rst_n, out_valid, out_center_row != '0)

  // Reset empties the output register.
  `SCC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind scaled_3x3_convolution scc_port_checker u_scc_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_scaled_result (out_scaled_result),
  .out_center_row    (out_center_row),
  .out_center_col    (out_center_col),
  .out_frame_end     (out_frame_end)
);

### dv/scaled_3x3_convolution_tb.sv
// Self-checking testbench for the scaled 3x3 convolution: streams pixel words,
// predicts each window sum, and checks every result word in order.
// Depends on scc_pkg and the scaled_3x3_convolution RTL.
`timescale 1ns / 1ps

module scaled_3x3_convolution_tb;

  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_PIXELS   = 1620;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_PCT        = 23;
  localparam int PRESSURE_WIDTH  = 16;
  localparam int PRESSURE_HEIGHT = 8;

  // Register indexes that the block does not decode.
  localparam logic [scc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [scc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic signed [scc_pkg::RESULT_BITS-1:0] scaled_result;
    logic [scc_pkg::HEIGHT_BITS-1:0]        center_row;
    logic [scc_pkg::CCOL_BITS-1:0]          center_col;
    logic                                   frame_end;
  } conv_sum_t;

  // Tracks registers, line stores and window, and keeps the sums still owed by the block.
  class conv_sum_tracker;
    logic [scc_pkg::CFG_DATA_BITS-1:0]  kernel_rows [scc_pkg::TAPS_PER_ROW];
    logic [scc_pkg::WIDTH_REG_BITS-1:0] width_reg;
    logic [scc_pkg::HEIGHT_BITS-1:0]    height_reg;
    logic [scc_pkg::PIXEL_BITS-1:0]     upper_line [scc_pkg::LINE_MAX_DEF];
    logic [scc_pkg::PIXEL_BITS-1:0]     lower_line [scc_pkg::LINE_MAX_DEF];
    logic [scc_pkg::PIXEL_BITS-1:0]     window [9];
    int unsigned                        col_visits [scc_pkg::LINE_MAX_DEF];
    int unsigned                        col_cnt;
    int unsigned                        row_cnt;
    conv_sum_t                          pending_sums [$];
    int                                 errors;

    function new();
      kernel_rows[0] = scc_pkg::KERNEL_TOP_RST;
      kernel_rows[1] = scc_pkg::KERNEL_MID_RST;
      kernel_rows[2] = scc_pkg::KERNEL_BOT_RST;
      width_reg = scc_pkg::WIDTH_RST;
      height_reg = scc_pkg::HEIGHT_RST;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
        col_visits[i] = 0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function int unsigned eff_width(logic [scc_pkg::WIDTH_REG_BITS-1:0] v);
      if (v < scc_pkg::MIN_DIM) return scc_pkg::MIN_DIM;
      if (v > scc_pkg::LINE_MAX_DEF) return scc_pkg::LINE_MAX_DEF;
      return int'(v);
    endfunction

    function int unsigned eff_height();
      return (height_reg < scc_pkg::MIN_DIM) ? scc_pkg::MIN_DIM : int'(height_reg);
    endfunction

    function void write_reg(logic [scc_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [scc_pkg::CFG_DATA_BITS-1:0] d);
      case (idx)
        scc_pkg::CFG_KERNEL_TOP:   kernel_rows[0] = d;
        scc_pkg::CFG_KERNEL_MID:   kernel_rows[1] = d;
        scc_pkg::CFG_KERNEL_BOT:   kernel_rows[2] = d;
        scc_pkg::CFG_IMAGE_WIDTH:  width_reg = d[scc_pkg::WIDTH_REG_BITS-1:0];
        scc_pkg::CFG_IMAGE_HEIGHT: height_reg = d[scc_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit at_image_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    // Pixels still needed to reach the end of the image in progress.
    function int unsigned pixels_left();
      int unsigned w, h, c, r;
      w = eff_width(width_reg);
      h = eff_height();
      c = (col_cnt >= w) ? 0 : col_cnt;
      r = (row_cnt >= h) ? 0 : row_cnt;
      return (h - r) * w - c;
    endfunction

    // A width change mid-image is safe once every column it reaches holds two
    // written rows, so no window can see a never-written line store entry.
    function bit width_safe(logic [scc_pkg::WIDTH_REG_BITS-1:0] v);
      int unsigned i;
      for (i = 0; i < eff_width(v); i++)
        if (col_visits[i] < 2) return 1'b0;
      return 1'b1;
    endfunction

    // Advances the window by one accepted pixel word and queues the sum it causes.
    function void take_pixel(logic [scc_pkg::PIXEL_BITS-1:0] px);
      int unsigned w, h, c, r;
      int unsigned k, j;
      logic [scc_pkg::PIXEL_BITS-1:0] top_px, mid_px;
      int acc;
      conv_sum_t res;
      w = eff_width(width_reg);
      h = eff_height();
      c = (col_cnt >= w) ? 0 : col_cnt;
      r = (row_cnt >= h) ? 0 : row_cnt;

      top_px = upper_line[c];
      mid_px = lower_line[c];
      upper_line[c] = mid_px;
      lower_line[c] = px;
      if (col_visits[c] < 2) col_visits[c]++;

      for (k = 0; k < 3; k++) begin
        window[k*3]   = window[k*3+1];
        window[k*3+1] = window[k*3+2];
      end
      window[2] = top_px;
      window[5] = mid_px;
      window[8] = px;

      // Interior centers only: the window must span three rows and three columns.
      if (r >= 2 && c >= 2) begin
        acc = scc_pkg::OFFSET_SCALED;
        for (j = 0; j < 3; j++)
          for (k = 0; k < 3; k++)
            acc += int'($signed(kernel_rows[j][k*scc_pkg::TAP_BITS +: scc_pkg::TAP_BITS])) *
                   int'(window[j*3+k]);
        res.scaled_result = acc[scc_pkg::RESULT_BITS-1:0];
        res.center_row = scc_pkg::HEIGHT_BITS'(r - 1);
        res.center_col = scc_pkg::CCOL_BITS'(c - 1);
        res.frame_end = (r == h - 1) && (c == w - 1);
        pending_sums.push_back(res);
      end

      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    // Compares one accepted result word with the oldest sum still owed.
    function void check_sum(conv_sum_t got);
      conv_sum_t want;
      if (pending_sums.size() == 0) begin
        $error("result with none expected: scaled_result %0d row %0d col %0d",
               $signed(got.scaled_result), got.center_row, got.center_col);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (got.scaled_result !== want.scaled_result) begin
        $error("scaled_result: expected %0d, got %0d",
               $signed(want.scaled_result), $signed(got.scaled_result));
        errors++;
      end
      if (got.center_row !== want.center_row) begin
        $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
        errors++;
      end
      if (got.center_col !== want.center_col) begin
        $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic [scc_pkg::PIXEL_BITS-1:0]         in_pixel;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [scc_pkg::RESULT_BITS-1:0] out_scaled_result;
  logic [scc_pkg::HEIGHT_BITS-1:0]        out_center_row;
  logic [scc_pkg::CCOL_BITS-1:0]          out_center_col;
  logic                                   out_frame_end;
  logic                                   cfg_we;
  logic [scc_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
  logic [scc_pkg::CFG_DATA_BITS-1:0]      cfg_data;

  conv_sum_tracker tracker = new();
  bit gaps_on = 1'b1;
  bit hold_armed = 1'b0;

  scaled_3x3_convolution u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one pixel word, with random idle cycles first, and holds it until accepted.
  task automatic send_pixel(input logic [scc_pkg::PIXEL_BITS-1:0] px);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_pixel(px);
  endtask

  task automatic write_reg(input logic [scc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [scc_pkg::CFG_DATA_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    tracker.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Border pixels give no result, so a DRAIN_CYCLES wait after the owed sums lets the pipe empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [scc_pkg::CFG_DATA_BITS-1:0] random_kernel();
    case ($urandom_range(7))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      2: return '0;
      default: return scc_pkg::CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [scc_pkg::PIXEL_BITS-1:0] random_pixel();
    return scc_pkg::PIXEL_BITS'($urandom_range(255, 0));
  endfunction

  // One random phase: new taps and geometry, then a full or partial image.
  task automatic run_phase(inout int fed);
    logic [scc_pkg::WIDTH_REG_BITS-1:0] w_val;
    logic [scc_pkg::HEIGHT_BITS-1:0] h_val;
    int unsigned n;
    int unsigned pick;
    int k;
    for (k = 0; k < scc_pkg::TAPS_PER_ROW; k++)
      if ($urandom_range(1))
        write_reg(scc_pkg::CFG_INDEX_BITS'(int'(scc_pkg::CFG_KERNEL_TOP) + k),
                  random_kernel());
    if ($urandom_range(15) == 0)
      write_reg(scc_pkg::CFG_INDEX_BITS'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                scc_pkg::CFG_DATA_BITS'($urandom));

    // Mostly small images; sometimes out-of-range low values, wide rows or tall images.
    pick = $urandom_range(19);
    if (pick < 13) begin
      w_val = scc_pkg::WIDTH_REG_BITS'($urandom_range(16, 3));
      h_val = scc_pkg::HEIGHT_BITS'($urandom_range(6, 3));
    end else if (pick < 15) begin
      w_val = scc_pkg::WIDTH_REG_BITS'($urandom_range(2, 0));
      h_val = scc_pkg::HEIGHT_BITS'($urandom_range(2, 0));
    end else if (pick < 17) begin
      w_val = scc_pkg::WIDTH_REG_BITS'($urandom_range(1023, 17));
      h_val = scc_pkg::HEIGHT_BITS'($urandom_range(6, 3));
    end else begin
      w_val = scc_pkg::WIDTH_REG_BITS'($urandom_range(16, 3));
      h_val = (pick == 19) ? '1 : scc_pkg::HEIGHT_BITS'($urandom_range(65535, 7));
    end
    if ($urandom_range(3) != 0 && (tracker.at_image_start() || tracker.width_safe(w_val)))
      write_reg(scc_pkg::CFG_IMAGE_WIDTH, scc_pkg::CFG_DATA_BITS'(w_val));
    if ($urandom_range(3) != 0)
      write_reg(scc_pkg::CFG_IMAGE_HEIGHT, scc_pkg::CFG_DATA_BITS'(h_val));

    // Usually finish the image; otherwise stop partway so the next phase
    // changes the geometry in the middle of an image.
    n = tracker.pixels_left();
    if (n > 150 || $urandom_range(4) == 0) n = $urandom_range(60, 1);
    repeat (n) send_pixel(random_pixel());
    fed += n;
    wait_idle();
  endtask

  // Whole image with no idling and one long output hold-off while pixel
  // words keep streaming in, so the pipe fills and stalls its input.
  task automatic run_pressure_image(inout int fed);
    int unsigned n;
    write_reg(scc_pkg::CFG_IMAGE_WIDTH, scc_pkg::CFG_DATA_BITS'(PRESSURE_WIDTH));
    write_reg(scc_pkg::CFG_IMAGE_HEIGHT, scc_pkg::CFG_DATA_BITS'(PRESSURE_HEIGHT));
    gaps_on = 1'b0;
    hold_armed = 1'b1;
    n = tracker.pixels_left();
    repeat (n) send_pixel(random_pixel());
    fed += n;
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Result side: check every accepted word, then pick the next stall value.
  initial begin : result_sink
    int hold_left;
    conv_sum_t got;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.scaled_result = out_scaled_result;
        got.center_row = out_center_row;
        got.center_col = out_center_col;
        got.frame_end = out_frame_end;
        tracker.check_sum(got);
        if (hold_armed) begin
          hold_armed = 1'b0;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int fed;
    int i;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    cfg_we <= 1'b0;
    cfg_index <= scc_pkg::CFG_KERNEL_TOP;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset taps over alternating black and white; width and height below range act as 3.
    write_reg(scc_pkg::CFG_IMAGE_WIDTH, '0);
    write_reg(scc_pkg::CFG_IMAGE_HEIGHT, 24'd1);
    for (i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
    wait_idle();

    // All taps at their most negative on full-scale pixels give the lowest sum.
    write_reg(scc_pkg::CFG_KERNEL_TOP, 24'h808080);
    write_reg(scc_pkg::CFG_KERNEL_MID, 24'h808080);
    write_reg(scc_pkg::CFG_KERNEL_BOT, 24'h808080);
    write_reg(scc_pkg::CFG_IMAGE_WIDTH, scc_pkg::CFG_DATA_BITS'(scc_pkg::MIN_DIM));
    write_reg(scc_pkg::CFG_IMAGE_HEIGHT, scc_pkg::CFG_DATA_BITS'(scc_pkg::MIN_DIM));
    repeat (9) send_pixel('1);
    wait_idle();

    // Most positive taps give the highest sum; an undecoded index must change nothing.
    write_reg(scc_pkg::CFG_KERNEL_TOP, 24'h7F7F7F);
    write_reg(scc_pkg::CFG_KERNEL_MID, 24'h7F7F7F);
    write_reg(scc_pkg::CFG_KERNEL_BOT, 24'h7F7F7F);
    write_reg(CFG_SPARE_LAST, '1);
    repeat (9) send_pixel('1);
    wait_idle();

    fed = 0;
    run_pressure_image(fed);
    while (fed < RANDOM_PIXELS) run_phase(fed);
    wait_idle();

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_line_store.sv
rtl/core/scc_cell.sv
rtl/core/scaled_3x3_convolution.sv
rtl/core/scc_port_checker.sv
dv/scaled_3x3_convolution_tb.sv
